>>> rtl/mts_pkg.sv
// shared constants, types and helpers of the mipmapped texture sampler
`default_nettype none
package mts_pkg;
  localparam int TEXEL_WORDS = 32768;
  localparam int ADDR_W      = $clog2(TEXEL_WORDS);
  localparam int MAX_SIDE    = 128;
  localparam int SIDE_W      = 8;
  localparam int MAX_LEVELS  = 8;
  localparam int LVL_W       = 3;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 64;

  localparam logic [2:0] CFG_BASE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_BASE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_MAX_LEVEL   = 3'd2;
  localparam logic [2:0] CFG_ADDR_MODE   = 3'd3;
  localparam logic [2:0] CFG_FILTER_MODE = 3'd4;
  localparam logic [2:0] CFG_COMP_COUNT  = 3'd5;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef logic [MAX_LEVELS-1:0][ADDR_W-1:0] off_tab_t;

  typedef struct packed {
    logic               action;
    logic [ADDR_W-1:0]  addr;
    logic [31:0]        word;
    logic [16:0]        u;
    logic [16:0]        v;
    logic [LVL_W-1:0]   l0;
    logic [LVL_W-1:0]   l1;
    logic [7:0]         f;
    logic               two;
    logic               bil;
  } q_ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [SIDE_W-1:0] lvl_dim(input logic [SIDE_W-1:0] side,
                                                input logic [LVL_W-1:0] l);
    logic [SIDE_W-1:0] d;
    d = side >> l;
    return (d == '0) ? SIDE_W'(1) : d;
  endfunction
endpackage
`default_nettype wire

>>> rtl/mts_front.sv
// front part: accepts items, normalizes coordinates, picks levels, queues work
`default_nettype none
module mts_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [mts_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire                              in_tuser,
  input  wire                              addr_mode,
  input  wire  [1:0]                       filter_mode,
  input  wire  [mts_pkg::LVL_W-1:0]        max_level,
  output logic                             q_valid,
  input  wire                              q_ready,
  output mts_pkg::q_ent_t                  q_data,
  output mts_pkg::q_stat_t                 q_stat
);
  import mts_pkg::*;

  q_ent_t          ent;
  q_ent_t          fifo_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push, pop;
  logic [3:0]      li;
  logic [4:0]      li1, lr, lsel;
  logic [12:0]     lod_rnd;
  logic            mip_lin;

  function automatic logic [16:0] norm(input logic [23:0] raw, input logic clamp);
    logic [16:0] r;
    if (!clamp) r = {1'b0, raw[15:0]};
    else if (raw[23]) r = '0;
    else if (raw[22:17] != '0 || (raw[16] && raw[15:0] != '0)) r = 17'h10000;
    else r = raw[16:0];
    return r;
  endfunction

  always_comb begin
    mip_lin     = filter_mode[0];
    li          = in_tdata[106:103];
    li1         = 5'(li) + 5'd1;
    lod_rnd     = 13'(in_tdata[106:95]) + 13'd128;
    lr          = lod_rnd[12:8];
    lsel        = mip_lin ? 5'(li) : lr;
    ent.action  = in_tuser;
    ent.addr    = in_tdata[14:0];
    ent.word    = in_tdata[46:15];
    ent.u       = norm(in_tdata[70:47], addr_mode);
    ent.v       = norm(in_tdata[94:71], addr_mode);
    ent.f       = in_tdata[102:95];
    ent.l0      = (lsel > 5'(max_level)) ? max_level : lsel[LVL_W-1:0];
    ent.l1      = (li1 > 5'(max_level)) ? max_level : li1[LVL_W-1:0];
    ent.two     = mip_lin && (ent.f != '0);
    ent.bil     = filter_mode[1];
  end

  assign in_tready   = (cnt_r != 2'd2);
  assign push        = in_tvalid && in_tready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_data      = fifo_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/mts_back.sv
// back part: texel memory, address and weight sequencer, filter and result register
`default_nettype none
module mts_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_valid,
  output logic                             q_ready,
  input  mts_pkg::q_ent_t                  q_data,
  input  mts_pkg::off_tab_t                off_tab,
  input  wire  [mts_pkg::SIDE_W-1:0]       side_w,
  input  wire  [mts_pkg::SIDE_W-1:0]       side_h,
  input  wire  [2:0]                       comp_cnt,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [mts_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import mts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_GEO, S_ADR, S_RDA, S_RDB, S_ACB, S_FIN} st_t;

  st_t               st_r;
  q_ent_t            ent_r;
  logic              lsel_r;
  logic [24:0]       x_r, y_r;
  logic [ADDR_W-1:0] addr_r [4];
  logic [16:0]       s_r, t_r;
  logic [32:0]       wt_r [4];
  logic [40:0]       acc_r [4];
  logic [23:0]       v0_r [4];
  logic [23:0]       v1_r [4];
  logic              ovalid_r;
  logic [15:0]       res_r [4];

  logic [31:0]       mem [TEXEL_WORDS];
  logic [31:0]       rd0_r, rd1_r;
  logic              mem_we;
  logic [ADDR_W-1:0] ra0, ra1;

  logic [LVL_W-1:0]  lvl;
  logic [SIDE_W-1:0] w, h;
  logic [8:0]        xi, yi, wm1, hm1;
  logic [7:0]        c0, r0, c1, r1;
  logic [26:0]       sdx, sdy;
  logic [16:0]       s_c, t_c, sn, tn;
  logic [15:0]       rw0, rw1;
  logic [ADDR_W-1:0] off;
  logic [40:0]       sum_a [4];
  logic [40:0]       sum_b [4];
  logic [23:0]       val_pt [4];
  logic [23:0]       val_bl [4];
  logic [33:0]       blend [4];
  logic [23:0]       single [4];
  logic [15:0]       res [4];
  logic              out_free;

  always_comb begin
    lvl = lsel_r ? ent_r.l1 : ent_r.l0;
    w   = lvl_dim(side_w, lvl);
    h   = lvl_dim(side_h, lvl);
    wm1 = 9'(w) - 9'd1;
    hm1 = 9'(h) - 9'd1;
    xi  = x_r[24:16];
    yi  = y_r[24:16];
    c0  = (xi > wm1) ? wm1[7:0] : xi[7:0];
    r0  = (yi > hm1) ? hm1[7:0] : yi[7:0];
    sdx = 27'({c0, 16'h8000}) - 27'(x_r);
    sdy = 27'({r0, 16'h8000}) - 27'(y_r);
    s_c = sdx[26] ? 17'(-sdx) : sdx[16:0];
    t_c = sdy[26] ? 17'(-sdy) : sdy[16:0];
    if (sdx[26]) c1 = (9'(c0) + 9'd1 < 9'(w)) ? c0 + 8'd1 : wm1[7:0];
    else         c1 = (c0 != '0) ? c0 - 8'd1 : 8'd0;
    if (sdy[26]) r1 = (9'(r0) + 9'd1 < 9'(h)) ? r0 + 8'd1 : hm1[7:0];
    else         r1 = (r0 != '0) ? r0 - 8'd1 : 8'd0;
    rw0 = 16'(r0) * 16'(w);
    rw1 = 16'(r1) * 16'(w);
    off = off_tab[lvl];
    sn  = 17'h10000 - s_r;
    tn  = 17'h10000 - t_r;
    for (int k = 0; k < 4; k++) begin
      sum_a[k]  = 41'(wt_r[0]) * 41'(rd0_r[8*k +: 8]) + 41'(wt_r[1]) * 41'(rd1_r[8*k +: 8]);
      sum_b[k]  = acc_r[k] + 41'(wt_r[2]) * 41'(rd0_r[8*k +: 8])
                + 41'(wt_r[3]) * 41'(rd1_r[8*k +: 8]) + 41'd32768;
      val_pt[k] = {rd0_r[8*k +: 8], 16'h0};
      val_bl[k] = sum_b[k][39:16];
      blend[k]  = 34'(v0_r[k]) * 34'(9'd256 - 9'(ent_r.f)) + 34'(v1_r[k]) * 34'(ent_r.f)
                + 34'd32768;
      single[k] = v0_r[k] + 24'd128;
      res[k]    = ent_r.two ? blend[k][31:16] : single[k][23:8];
      if (3'(k) >= comp_cnt) res[k] = '0;
    end
    ra0      = (st_r == S_RDA) ? addr_r[0] : addr_r[2];
    ra1      = (st_r == S_RDA) ? addr_r[1] : addr_r[3];
    q_ready  = (st_r == S_IDLE);
    mem_we   = q_ready && q_valid && (q_data.action == ACT_WRITE);
    out_free = !ovalid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[q_data.addr] <= q_data.word;
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ovalid_r <= 1'b0;
      lsel_r   <= 1'b0;
    end else begin
      if (ovalid_r && out_tready && st_r != S_FIN) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid && q_data.action == ACT_SAMPLE) begin
            ent_r  <= q_data;
            lsel_r <= 1'b0;
            st_r   <= S_GEO;
          end
        end
        S_GEO: begin
          x_r  <= 25'(ent_r.u) * 25'(w);
          y_r  <= 25'(17'h10000 - ent_r.v) * 25'(h);
          st_r <= S_ADR;
        end
        S_ADR: begin
          addr_r[0] <= ADDR_W'(off + ADDR_W'(rw0) + ADDR_W'(c0));
          addr_r[1] <= ADDR_W'(off + ADDR_W'(rw0) + ADDR_W'(c1));
          addr_r[2] <= ADDR_W'(off + ADDR_W'(rw1) + ADDR_W'(c0));
          addr_r[3] <= ADDR_W'(off + ADDR_W'(rw1) + ADDR_W'(c1));
          s_r  <= s_c;
          t_r  <= t_c;
          st_r <= S_RDA;
        end
        S_RDA: begin
          wt_r[0] <= 33'(34'(sn) * 34'(tn));
          wt_r[1] <= 33'(34'(s_r) * 34'(tn));
          wt_r[2] <= 33'(34'(sn) * 34'(t_r));
          wt_r[3] <= 33'(34'(s_r) * 34'(t_r));
          st_r    <= S_RDB;
        end
        S_RDB: begin
          if (ent_r.bil) begin
            for (int k = 0; k < 4; k++) acc_r[k] <= sum_a[k];
            st_r <= S_ACB;
          end else begin
            for (int k = 0; k < 4; k++) begin
              if (lsel_r) v1_r[k] <= val_pt[k];
              else        v0_r[k] <= val_pt[k];
            end
            if (ent_r.two && !lsel_r) begin
              lsel_r <= 1'b1;
              st_r   <= S_GEO;
            end else begin
              st_r <= S_FIN;
            end
          end
        end
        S_ACB: begin
          for (int k = 0; k < 4; k++) begin
            if (lsel_r) v1_r[k] <= val_bl[k];
            else        v0_r[k] <= val_bl[k];
          end
          if (ent_r.two && !lsel_r) begin
            lsel_r <= 1'b1;
            st_r   <= S_GEO;
          end else begin
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            for (int k = 0; k < 4; k++) res_r[k] <= res[k];
            ovalid_r <= 1'b1;
            st_r     <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {res_r[3], res_r[2], res_r[1], res_r[0]};
endmodule
`default_nettype wire

>>> rtl/mipmapped_texture_sampler_unit.sv
// top level of the mipmapped texture sampler: config registers, level offsets, front and back
//
// channel | direction | payload
// in_     | input     | tuser: action; tdata: texel_address, texel_word, u, v, level_of_detail
// out_    | output    | tdata: comp0, comp1, comp2, comp3
// cfg_    | input     | index 0..5: base_width .. component_count
//
// a write item is taken by the back part in its idle state; a sample steps the address
// and weight sequencer around the two-read-port texel memory through geometry, address,
// two read states and, for bilinear, an accumulate state, once per level, then finish
// a two-entry queue lets the front keep accepting while the back works, until the queue is full
// rst_n is synchronous; the texel memory is not cleared
`default_nettype none
module mipmapped_texture_sampler_unit (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [111:0] in_tdata,   // texel_address, texel_word, u_coord, v_coord, level_of_detail
  input  wire          in_tuser,   // action
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [63:0]  out_tdata,  // comp0, comp1, comp2, comp3
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_index,
  input  wire  [7:0]   cfg_wdata
);
  import mts_pkg::*;

  logic [7:0]        bw_r, bh_r;
  logic [LVL_W-1:0]  max_level_r;
  logic              addr_mode_r;
  logic [1:0]        filter_mode_r;
  logic [2:0]        comp_cnt_r;
  logic [SIDE_W-1:0] side_w, side_h;
  logic [2:0]        cnt_eff;
  logic [15:0]       prod_r [MAX_LEVELS];
  off_tab_t          off_r;
  logic [18:0]       off_sum [MAX_LEVELS];
  logic              q_valid, q_ready;
  q_ent_t            q_data;
  q_stat_t           q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r          <= 8'd1;
      bh_r          <= 8'd1;
      max_level_r   <= '0;
      addr_mode_r   <= 1'b0;
      filter_mode_r <= 2'd0;
      comp_cnt_r    <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_WIDTH:  bw_r          <= cfg_wdata;
        CFG_BASE_HEIGHT: bh_r          <= cfg_wdata;
        CFG_MAX_LEVEL:   max_level_r   <= cfg_wdata[LVL_W-1:0];
        CFG_ADDR_MODE:   addr_mode_r   <= cfg_wdata[0];
        CFG_FILTER_MODE: filter_mode_r <= cfg_wdata[1:0];
        CFG_COMP_COUNT:  comp_cnt_r    <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    side_w  = (bw_r == '0) ? SIDE_W'(1) : ((bw_r > 8'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : bw_r);
    side_h  = (bh_r == '0) ? SIDE_W'(1) : ((bh_r > 8'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : bh_r);
    cnt_eff = (comp_cnt_r == '0) ? 3'd1 : ((comp_cnt_r > 3'd4) ? 3'd4 : comp_cnt_r);
    for (int l = 0; l < MAX_LEVELS; l++) begin
      off_sum[l] = '0;
      for (int k = 0; k < l; k++) off_sum[l] = off_sum[l] + 19'(prod_r[k]);
    end
  end

  // level sizes and start offsets follow the config registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_LEVELS; k++) begin
      prod_r[k] <= 16'(lvl_dim(side_w, LVL_W'(k))) * 16'(lvl_dim(side_h, LVL_W'(k)));
      off_r[k]  <= off_sum[k][ADDR_W-1:0];
    end
  end

  mts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .addr_mode    (addr_mode_r),
    .filter_mode  (filter_mode_r),
    .max_level    (max_level_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .q_stat       (q_stat)
  );

  mts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .off_tab    (off_r),
    .side_w     (side_w),
    .side_h     (side_h),
    .comp_cnt   (cnt_eff),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_rst_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cnt_eff == 3'd1 |-> out_tdata[63:16] == '0)
    else $error("unused components not zero");

  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && q_stat.empty |=> !q_stat.empty)
    else $error("accepted item lost from queue");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("item accepted into full queue");
endmodule
`default_nettype wire
